// ===== design/ffgc_pkg.sv =====
// ffgc_pkg: shared types and constants of the first-fit graph coloring core
// no dependencies

package ffgc_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VTX_W   = 6;
  localparam int unsigned COLOR_W = 7;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // register word index, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_EDGE = 2'd0,
    CMD_RUN      = 2'd1,
    CMD_CLEAR    = 2'd2
  } ffgc_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_A,
    ST_WR_B,
    ST_ROW,
    ST_TEST
  } ffgc_state_e;

endpackage

// ===== design/ffgc_if.sv =====
// ffgc_req_if / ffgc_rsp_if: valid/ready channels of the coloring core
// depends on ffgc_pkg

interface ffgc_req_if;
  import ffgc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VTX_W-1:0]   vertex_a;
  logic [VTX_W-1:0]   vertex_b;
  modport source (output valid, output command, output vertex_a, output vertex_b, input ready);
  modport sink   (input valid, input command, input vertex_a, input vertex_b, output ready);
endinterface

interface ffgc_rsp_if;
  import ffgc_pkg::*;
  logic               valid;
  logic               ready;
  logic [VTX_W-1:0]   vertex;
  logic [COLOR_W-1:0] color;
  logic               last;
  modport source (output valid, output vertex, output color, output last, input ready);
  modport sink   (input valid, input vertex, input color, input last, output ready);
endinterface

// ===== design/first_fit_graph_coloring_core.sv =====
// first_fit_graph_coloring_core: edge store and greedy first-fit coloring engine
// depends on ffgc_pkg, ffgc_req_if, ffgc_rsp_if
//
//   port     | dir | handshake            | payload
//   ---------+-----+----------------------+--------------------------------
//   req_i    | in  | valid / ready        | command, vertex_a, vertex_b
//   rsp_o    | out | valid / ready        | vertex, color, last
//   apb      | in  | psel/penable/pready  | vertex_count at byte address 0
//
// one request at a time: add edge reads and writes both rows (ST_WR_A, ST_WR_B), clear
// stays in ST_IDLE, a run passes ST_ROW and ST_TEST per vertex, scanning the color-class memory
// reset leaves an empty edge store (row valid bits) and vertex_count = MAX_VERTICES
// a result waits in the output register; the run stalls only when it is still full

module first_fit_graph_coloring_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ffgc_req_if.sink                      req_i,
  ffgc_rsp_if.source                    rsp_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [ffgc_pkg::APB_AW-1:0]   paddr_i,
  input  logic [ffgc_pkg::APB_DW-1:0]   pwdata_i,
  output logic [ffgc_pkg::APB_DW-1:0]   prdata_o,
  output logic                          pready_o
);
  import ffgc_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam logic [COLOR_W-1:0] MaxV = COLOR_W'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] OneBit = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  ffgc_state_e              state_q, state_d;
  logic [VW-1:0]            v_q, v_d;
  logic [VW-1:0]            k_q, k_d;
  logic [VW-1:0]            ea_q, ea_d;
  logic [VW-1:0]            eb_q, eb_d;
  logic [COLOR_W-1:0]       n_q, n_d;
  logic [COLOR_W-1:0]       vc_q, vc_d;
  logic [MAX_VERTICES-1:0]  row_q, row_d;
  logic [MAX_VERTICES-1:0]  adj_vld_q, adj_vld_d;
  logic [MAX_VERTICES-1:0]  cls_vld_q, cls_vld_d;
  logic                     out_vld_q, out_vld_d;
  logic [VTX_W-1:0]         out_vertex_q, out_vertex_d;
  logic [COLOR_W-1:0]       out_color_q, out_color_d;
  logic                     out_last_q, out_last_d;

  logic [MAX_VERTICES-1:0]  adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]  cls_mem [MAX_VERTICES];
  logic                     adj_re, adj_we, cls_re, cls_we;
  logic [VW-1:0]            adj_raddr, adj_waddr, cls_raddr, cls_waddr;
  logic [MAX_VERTICES-1:0]  adj_wdata, cls_wdata;
  logic [MAX_VERTICES-1:0]  adj_rdata_q, cls_rdata_q;
  logic                     adj_rvld_q, cls_rvld_q;

  logic [MAX_VERTICES-1:0]  adj_row, cls_row;
  logic                     req_acc, slot_free, edge_ok, is_last, cfg_wr;
  logic [COLOR_W-1:0]       n_clamp;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign req_acc       = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.vertex  = out_vertex_q;
  assign rsp_o.color   = out_color_q;
  assign rsp_o.last    = out_last_q;

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o = (paddr_i[2] == REG_VERTEX_COUNT) ? APB_DW'(vc_q) : '0;

  assign adj_row   = adj_rvld_q ? adj_rdata_q : '0;
  assign cls_row   = cls_rvld_q ? cls_rdata_q : '0;
  assign slot_free = !out_vld_q || rsp_o.ready;
  assign is_last   = (COLOR_W'(v_q) + COLOR_W'(1)) == n_q;
  assign edge_ok   = ({1'b0, req_i.vertex_a} < MaxV) && ({1'b0, req_i.vertex_b} < MaxV);
  assign n_clamp   = (vc_q == '0) ? COLOR_W'(1) : ((vc_q > MaxV) ? MaxV : vc_q);

  always_comb begin
    state_d      = state_q;
    v_d          = v_q;
    k_d          = k_q;
    ea_d         = ea_q;
    eb_d         = eb_q;
    n_d          = n_q;
    vc_d         = vc_q;
    row_d        = row_q;
    adj_vld_d    = adj_vld_q;
    cls_vld_d    = cls_vld_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_vertex_d = out_vertex_q;
    out_color_d  = out_color_q;
    out_last_d   = out_last_q;
    adj_re       = 1'b0;
    adj_we       = 1'b0;
    adj_raddr    = '0;
    adj_waddr    = '0;
    adj_wdata    = '0;
    cls_re       = 1'b0;
    cls_we       = 1'b0;
    cls_raddr    = '0;
    cls_waddr    = '0;
    cls_wdata    = '0;

    if (cfg_wr && paddr_i[2] == REG_VERTEX_COUNT) begin
      vc_d = pwdata_i[COLOR_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (ffgc_cmd_e'(req_i.command))
            CMD_ADD_EDGE: begin
              if (edge_ok) begin
                ea_d      = req_i.vertex_a[VW-1:0];
                eb_d      = req_i.vertex_b[VW-1:0];
                adj_re    = 1'b1;
                adj_raddr = req_i.vertex_a[VW-1:0];
                state_d   = ST_WR_A;
              end
            end
            CMD_RUN: begin
              cls_vld_d = '0;
              n_d       = n_clamp;
              v_d       = '0;
              adj_re    = 1'b1;
              adj_raddr = '0;
              state_d   = ST_ROW;
            end
            CMD_CLEAR: begin
              adj_vld_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WR_A: begin
        adj_we           = 1'b1;
        adj_waddr        = ea_q;
        adj_wdata        = adj_row | (OneBit << eb_q);
        adj_vld_d[ea_q]  = 1'b1;
        adj_re           = 1'b1;
        adj_raddr        = eb_q;
        state_d          = ST_WR_B;
      end
      ST_WR_B: begin
        adj_we           = 1'b1;
        adj_waddr        = eb_q;
        adj_wdata        = adj_row | (OneBit << ea_q);
        adj_vld_d[eb_q]  = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_ROW: begin
        row_d     = adj_row;
        k_d       = '0;
        cls_re    = 1'b1;
        cls_raddr = '0;
        state_d   = ST_TEST;
      end
      ST_TEST: begin
        if (|(row_q & cls_row)) begin
          // a colored neighbor holds this color, try the next one
          k_d       = k_q + VW'(1);
          cls_re    = 1'b1;
          cls_raddr = k_q + VW'(1);
        end else if (slot_free) begin
          cls_we          = 1'b1;
          cls_waddr       = k_q;
          cls_wdata       = cls_row | (OneBit << v_q);
          cls_vld_d[k_q]  = 1'b1;
          out_vld_d       = 1'b1;
          out_vertex_d    = VTX_W'(v_q);
          out_color_d     = COLOR_W'(k_q) + COLOR_W'(1);
          out_last_d      = is_last;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            v_d       = v_q + VW'(1);
            adj_re    = 1'b1;
            adj_raddr = v_q + VW'(1);
            state_d   = ST_ROW;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      v_q        <= '0;
      k_q        <= '0;
      n_q        <= MaxV;
      vc_q       <= MaxV;
      adj_vld_q  <= '0;
      cls_vld_q  <= '0;
      out_vld_q  <= 1'b0;
      adj_rvld_q <= 1'b0;
      cls_rvld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      v_q       <= v_d;
      k_q       <= k_d;
      n_q       <= n_d;
      vc_q      <= vc_d;
      adj_vld_q <= adj_vld_d;
      cls_vld_q <= cls_vld_d;
      out_vld_q <= out_vld_d;
      if (adj_re) begin
        adj_rvld_q <= adj_vld_q[adj_raddr];
      end
      if (cls_re) begin
        cls_rvld_q <= cls_vld_q[cls_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ea_q         <= ea_d;
    eb_q         <= eb_d;
    row_q        <= row_d;
    out_vertex_q <= out_vertex_d;
    out_color_q  <= out_color_d;
    out_last_q   <= out_last_d;
  end

  // adjacency rows, one bit per neighbor
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata_q <= adj_mem[adj_raddr];
    end
  end

  // color classes, one bit per vertex holding that color
  always_ff @(posedge clk_i) begin
    if (cls_we) begin
      cls_mem[cls_waddr] <= cls_wdata;
    end
    if (cls_re) begin
      cls_rdata_q <= cls_mem[cls_raddr];
    end
  end

  a_color_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST) |-> (k_q <= v_q))
    else $error("color index beyond vertex index");

  a_vertex_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST || state_q == ST_ROW) |-> (COLOR_W'(v_q) < n_q))
    else $error("vertex index beyond vertex count");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_we && is_last) |=> (state_q == ST_IDLE && out_vld_q && out_last_q))
    else $error("last result did not end the run");

  a_run_clears_classes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.command == CMD_RUN) |=> (cls_vld_q == '0 && state_q == ST_ROW))
    else $error("run did not start from empty color classes");

endmodule

// ===== tb/first_fit_graph_coloring_core_tb.sv =====
`timescale 1ns / 1ps
// first_fit_graph_coloring_core_tb: self-checking bench for the first-fit coloring core
// keeps its own edge rows and vertex colors, predicts every result and checks it in order
// depends on ffgc_pkg, ffgc_req_if, ffgc_rsp_if and first_fit_graph_coloring_core

module first_fit_graph_coloring_core_tb;
  import ffgc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned      NUM_VTX    = 64;
  localparam int               HOLD_CYCLES  = 400;
  localparam int               QUIET_LIMIT  = 5000;
  localparam int               DRAIN_CYCLES = 8;
  localparam int               END_CYCLES   = 20;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
  } edge_req_t;

  typedef struct packed {
    logic [VTX_W-1:0]   vertex;
    logic [COLOR_W-1:0] color;
    logic               last;
  } coloring_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              req_valid = 1'b0;
  edge_req_t         req_item  = '0;
  logic              rsp_ready = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata_o;
  logic              pready_o;

  ffgc_req_if req_if();
  ffgc_rsp_if rsp_if();

  assign req_if.valid    = req_valid;
  assign req_if.command  = req_item.cmd;
  assign req_if.vertex_a = req_item.a;
  assign req_if.vertex_b = req_item.b;
  assign rsp_if.ready    = rsp_ready;

  first_fit_graph_coloring_core #(
    .MAX_VERTICES(NUM_VTX)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_if),
    .rsp_o    (rsp_if),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_o (prdata_o),
    .pready_o (pready_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [NUM_VTX-1:0] edge_rows    [NUM_VTX];
  logic [COLOR_W-1:0] vertex_color [NUM_VTX];
  logic [COLOR_W-1:0] vertex_limit = 7'd64;

  edge_req_t pending_reqs[$];
  coloring_t expected_colorings[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_arm  = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  int mismatches      = 0;
  int reqs_accepted   = 0;
  int runs_accepted   = 0;
  int results_checked = 0;
  int max_color_seen  = 0;

  initial begin
    for (int i = 0; i < NUM_VTX; i++) begin
      edge_rows[i]    = '0;
      vertex_color[i] = '0;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // apply one accepted request to the edge store and queue the colors it yields
  function automatic void color_request(edge_req_t r);
    logic [NUM_VTX-1:0] taken;
    int n;
    int c;
    coloring_t res;
    case (r.cmd)
      CMD_ADD_EDGE: begin
        edge_rows[r.a][r.b] = 1'b1;
        edge_rows[r.b][r.a] = 1'b1;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NUM_VTX; i++) edge_rows[i] = '0;
      end
      CMD_RUN: begin
        n = (vertex_limit == 0) ? 1 : (vertex_limit > NUM_VTX) ? NUM_VTX : int'(vertex_limit);
        runs_accepted++;
        for (int i = 0; i < NUM_VTX; i++) vertex_color[i] = '0;
        for (int v = 0; v < n; v++) begin
          taken = '0;
          for (int j = 0; j < NUM_VTX; j++) begin
            if (edge_rows[v][j] && vertex_color[j] != 0) taken[vertex_color[j] - 1] = 1'b1;
          end
          c = 1;
          while (c <= n && taken[c-1]) c++;
          vertex_color[v] = COLOR_W'(c);
          res.vertex = VTX_W'(v);
          res.color  = COLOR_W'(c);
          res.last   = (v == n - 1);
          expected_colorings.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    edge_req_t nxt;
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_item  <= '0;
    end else begin
      if (req_valid && req_if.ready) begin
        color_request(req_item);
        reqs_accepted++;
      end
      if (!req_valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          req_item  <= nxt;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    coloring_t want;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        if (expected_colorings.size() == 0) begin
          report_mismatch("result with nothing expected, vertex", rsp_if.vertex, -1);
        end else begin
          want = expected_colorings.pop_front();
          if (rsp_if.vertex !== want.vertex)
            report_mismatch("vertex", rsp_if.vertex, want.vertex);
          if (rsp_if.color !== want.color)
            report_mismatch($sformatf("color of vertex %0d", want.vertex), rsp_if.color,
                            want.color);
          if (rsp_if.last !== want.last)
            report_mismatch($sformatf("last of vertex %0d", want.vertex), rsp_if.last,
                            want.last);
          results_checked++;
          if (int'(want.color) > max_color_seen) max_color_seen = want.color;
        end
      end
      rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic void push_req(logic [CMD_W-1:0] cmd, logic [VTX_W-1:0] a,
                                   logic [VTX_W-1:0] b);
    edge_req_t r;
    r.cmd = cmd;
    r.a   = a;
    r.b   = b;
    pending_reqs.push_back(r);
  endfunction

  task automatic apb_access(logic wr, logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_VERTEX_COUNT, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rdata   = prdata_o;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_colorings.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_vertex_count(logic [COLOR_W-1:0] cnt);
    logic [APB_DW-1:0] rd;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    apb_access(1'b1, APB_DW'(cnt), rd);
    vertex_limit = cnt;
    apb_access(1'b0, '0, rd);
    if (rd !== APB_DW'(cnt)) report_mismatch("vertex_count readback", rd, cnt);
  endtask

  // 0 no idling, 1 sender idle, 2 receiver stalls, 3 both
  task automatic set_idling(int mode);
    send_idle_pct  <= (mode == 1) ? 65 : (mode == 3) ? 15 : 0;
    recv_stall_pct <= (mode == 2) ? 65 : (mode == 3) ? 15 : 0;
  endtask

  // clear now and then, a handful of edges mostly among the vertices in use, sometimes an unused command, then a run
  task automatic add_sequence(int n_eff, inout int added);
    int span;
    int k;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    span = (n_eff + 2 > NUM_VTX) ? NUM_VTX : n_eff + 2;
    if ($urandom_range(3) == 0) begin
      push_req(CMD_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
      added++;
    end
    k = $urandom_range(10, 1);
    repeat (k) begin
      if ($urandom_range(9) == 0) begin
        a = VTX_W'($urandom);
        b = VTX_W'($urandom);
      end else begin
        a = VTX_W'($urandom_range(span - 1));
        b = ($urandom_range(11) == 0) ? a : VTX_W'($urandom_range(span - 1));
      end
      push_req(CMD_ADD_EDGE, a, b);
      added++;
    end
    if ($urandom_range(15) == 0) push_req(CMD_UNUSED, VTX_W'($urandom), VTX_W'($urandom));
    push_req(CMD_RUN, VTX_W'($urandom), VTX_W'($urandom));
    added++;
  endtask

  initial begin : stimulus
    logic [APB_DW-1:0] rd;
    logic [COLOR_W-1:0] phase_counts [8];
    int n_eff;
    int phase_items;
    phase_counts = '{7'd3, 7'd64, 7'd127, 7'd1, 7'd16, 7'd0, 7'd9, 7'd40};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, '0, rd);
    if (rd !== APB_DW'(7'd64)) report_mismatch("vertex_count after reset", rd, 64);

    // directed: all 64 vertices at the reset count
    push_req(CMD_CLEAR,    6'd63, 6'd63);
    push_req(CMD_UNUSED,   6'd63, 6'd0);
    push_req(CMD_ADD_EDGE, 6'd0,  6'd63);
    push_req(CMD_ADD_EDGE, 6'd63, 6'd0);
    push_req(CMD_ADD_EDGE, 6'd5,  6'd5);
    push_req(CMD_ADD_EDGE, 6'd1,  6'd2);
    push_req(CMD_ADD_EDGE, 6'd1,  6'd3);
    push_req(CMD_ADD_EDGE, 6'd1,  6'd4);
    push_req(CMD_ADD_EDGE, 6'd2,  6'd3);
    push_req(CMD_ADD_EDGE, 6'd2,  6'd4);
    push_req(CMD_ADD_EDGE, 6'd3,  6'd4);
    push_req(CMD_RUN,      6'd63, 6'd63);
    push_req(CMD_ADD_EDGE, 6'd62, 6'd61);
    push_req(CMD_RUN,      6'd0,  6'd0);

    // directed: count 0 runs one vertex, count above the maximum runs all of them
    set_vertex_count(7'd0);
    push_req(CMD_RUN, 6'd0, 6'd0);
    set_vertex_count(7'd127);
    push_req(CMD_RUN, 6'd0, 6'd0);
    set_vertex_count(7'd2);
    push_req(CMD_CLEAR,    6'd0, 6'd0);
    push_req(CMD_ADD_EDGE, 6'd0, 6'd1);
    push_req(CMD_RUN,      6'd0, 6'd0);
    set_vertex_count(7'd5);
    push_req(CMD_ADD_EDGE, 6'd4, 6'd0);
    push_req(CMD_ADD_EDGE, 6'd4, 6'd1);
    push_req(CMD_ADD_EDGE, 6'd1, 6'd2);
    push_req(CMD_RUN,      6'd0, 6'd0);
    set_vertex_count(7'd1);
    push_req(CMD_RUN, 6'd0, 6'd0);

    // random phases, one vertex count and one idling mode each
    for (int p = 0; p < 8; p++) begin
      set_vertex_count(phase_counts[p]);
      set_idling(p % 4);
      n_eff = (phase_counts[p] == 0) ? 1 :
              (phase_counts[p] > NUM_VTX) ? NUM_VTX : int'(phase_counts[p]);
      phase_items = 0;
      while (phase_items < 22) add_sequence(n_eff, phase_items);
      if (p == 4) begin
        hold_arm <= 1'b1;
        @(posedge clk_i);
        hold_arm <= 1'b0;
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d runs, %0d vertex colors checked, highest color %0d",
             reqs_accepted, runs_accepted, results_checked, max_color_seen);
    $display("vertex counts from 0 to 127 under four idling mixes and one long output hold-off");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
